// ===== rtl/upe_pkg.sv =====
// Package for the URL percent encoder: field widths, character codes and helpers.
`default_nettype none

package upe_pkg;

  localparam int CpW      = 21;
  localparam int CharW    = 7;
  localparam int MaxChars = 12;
  localparam int CntW     = 4;
  localparam int InDataW  = 24;
  localparam int OutDataW = 8;

  localparam logic [CharW-1:0] ChPercent = 7'h25;
  localparam logic [CharW-1:0] ChZero    = 7'h30;
  localparam logic [CharW-1:0] ChUpperA  = 7'h41;

  typedef logic [CharW-1:0] char_t;
  typedef logic [7:0]       byte_t;

  // True for codepoints that pass through unescaped.
  function automatic logic is_literal(input logic [CpW-1:0] c);
    logic [CharW-1:0] a;
    logic             hit;
    a   = c[CharW-1:0];
    hit = a inside {[7'h61:7'h7A], [7'h41:7'h5A], [7'h30:7'h39],
                    7'h2D, 7'h2E, 7'h5F, 7'h7E, 7'h3A, 7'h2F, 7'h3F, 7'h23,
                    7'h5B, 7'h5D, 7'h40, 7'h21, 7'h24, 7'h26, 7'h27, 7'h28,
                    7'h29, 7'h2A, 7'h2B, 7'h2C, 7'h3B, 7'h3D};
    return hit && (c[CpW-1:CharW] == '0);
  endfunction

  // Uppercase hex digit of one nibble.
  function automatic char_t hex_char(input logic [3:0] d);
    char_t r;
    if (d < 4'd10) begin
      r = ChZero + char_t'(d);
    end else begin
      r = ChUpperA + char_t'(d - 4'd10);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/url_percent_encoder.sv =====
// URL percent encoder: one codepoint in, 1 to 12 ASCII characters out.
// Throughput: one output character per cycle while out_tready is high; an item gives
// 1, 3, 6, 9 or 12 characters, sent by the character serializer at the output.
// Pipeline: input reg, UTF-8 encode, hex expand, serializer; an item may enter every
// cycle unless a busy serializer or a low out_tready stalls the chain.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
`default_nettype none

module url_percent_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [upe_pkg::InDataW-1:0]   in_tdata,   // [20:0] codepoint, [23:21] zero
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [upe_pkg::OutDataW-1:0]       out_tdata,  // [6:0] out_char, [7] zero
  output logic                               out_tlast   // last_of_item
);

  // Stage 1: captured codepoint
  logic                       s1_v_r;
  logic [upe_pkg::CpW-1:0]    s1_cp_r;
  // Stage 2: classification and UTF-8 bytes
  logic                       s2_v_r;
  logic                       s2_pass_r;
  logic [2:0]                 s2_n_r;
  upe_pkg::byte_t [3:0]       s2_b_r;
  // Stage 3: expanded characters
  logic                       s3_v_r;
  upe_pkg::char_t [upe_pkg::MaxChars-1:0] s3_ch_r;
  logic [upe_pkg::CntW-1:0]   s3_cnt_r;
  // Serializer
  logic                       ser_v_r;
  upe_pkg::char_t [upe_pkg::MaxChars-1:0] ser_ch_r;
  logic [upe_pkg::CntW-1:0]   ser_rem_r;

  logic ser_load, s3_en, s2_en, s1_en;

  upe_pkg::byte_t [3:0]       b_nxt;
  logic [2:0]                 n_nxt;
  upe_pkg::char_t [upe_pkg::MaxChars-1:0] ch_nxt;
  logic [upe_pkg::CntW-1:0]   cnt_nxt;

  // Stall chain: a stage advances when it is empty or its successor takes its beat
  assign ser_load  = s3_v_r && (!ser_v_r || (out_tready && ser_rem_r == upe_pkg::CntW'(1)));
  assign s3_en     = !s3_v_r || ser_load;
  assign s2_en     = !s2_v_r || s3_en;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = s1_en;

  // UTF-8 encode
  always_comb begin
    b_nxt = '0;
    if (s1_cp_r < 21'h80) begin
      n_nxt    = 3'd1;
      b_nxt[0] = s1_cp_r[7:0];
    end else if (s1_cp_r < 21'h800) begin
      n_nxt    = 3'd2;
      b_nxt[0] = {3'b110, s1_cp_r[10:6]};
      b_nxt[1] = {2'b10, s1_cp_r[5:0]};
    end else if (s1_cp_r < 21'h10000) begin
      n_nxt    = 3'd3;
      b_nxt[0] = {4'b1110, s1_cp_r[15:12]};
      b_nxt[1] = {2'b10, s1_cp_r[11:6]};
      b_nxt[2] = {2'b10, s1_cp_r[5:0]};
    end else begin
      n_nxt    = 3'd4;
      b_nxt[0] = {5'b11110, s1_cp_r[20:18]};
      b_nxt[1] = {2'b10, s1_cp_r[17:12]};
      b_nxt[2] = {2'b10, s1_cp_r[11:6]};
      b_nxt[3] = {2'b10, s1_cp_r[5:0]};
    end
  end

  // Expand each byte into '%' and two hex digits, or pass a literal through as one character
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ch_nxt[3*i]   = upe_pkg::ChPercent;
      ch_nxt[3*i+1] = upe_pkg::hex_char(s2_b_r[i][7:4]);
      ch_nxt[3*i+2] = upe_pkg::hex_char(s2_b_r[i][3:0]);
    end
    if (s2_pass_r) begin
      ch_nxt[0] = s2_b_r[0][upe_pkg::CharW-1:0];
      cnt_nxt   = upe_pkg::CntW'(1);
    end else begin
      cnt_nxt   = upe_pkg::CntW'(3 * s2_n_r);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      ser_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r <= in_tvalid;
      if (s2_en) s2_v_r <= s1_v_r;
      if (s3_en) s3_v_r <= s2_v_r;
      if (ser_load) begin
        ser_v_r <= 1'b1;
      end else if (ser_v_r && out_tready && ser_rem_r == upe_pkg::CntW'(1)) begin
        ser_v_r <= 1'b0;
      end
    end
  end

  // Payload: hold on stall, advance otherwise
  always_ff @(posedge clk) begin
    if (s1_en) s1_cp_r <= in_tdata[upe_pkg::CpW-1:0];
    if (s2_en) begin
      s2_pass_r <= upe_pkg::is_literal(s1_cp_r);
      s2_n_r    <= n_nxt;
      s2_b_r    <= b_nxt;
    end
    if (s3_en) begin
      s3_ch_r  <= ch_nxt;
      s3_cnt_r <= cnt_nxt;
    end
    if (ser_load) begin
      ser_ch_r  <= s3_ch_r;
      ser_rem_r <= s3_cnt_r;
    end else if (ser_v_r && out_tready) begin
      ser_ch_r  <= {upe_pkg::CharW'(0), ser_ch_r[upe_pkg::MaxChars-1:1]};
      ser_rem_r <= ser_rem_r - upe_pkg::CntW'(1);
    end
  end

  assign out_tvalid = ser_v_r;
  assign out_tdata  = {1'b0, ser_ch_r[0]};
  assign out_tlast  = (ser_rem_r == upe_pkg::CntW'(1));

endmodule

`default_nettype wire

// ===== rtl/upe_checker.sv =====
// Port-level checker for the URL percent encoder and its bind.
`default_nettype none

module upe_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic [upe_pkg::InDataW-1:0] in_tdata,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [upe_pkg::OutDataW-1:0] out_tdata,
  input wire logic                        out_tlast
);

  // Waiting input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input beat changed before acceptance");

  // Stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed under stall");

  // An item's characters follow without gaps until its last one
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside an item");

  // Output is 7-bit ASCII
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("output pad bit set");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind url_percent_encoder upe_checker u_upe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== dv/tb_url_percent_encoder.sv =====
// Testbench for url_percent_encoder: random stream stimulus with a self-checking character scoreboard.
module tb_url_percent_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import upe_pkg::*;

  localparam int RandomItems = 500;
  localparam int QuietTail   = 80;
  localparam int DrainCycles = 24;

  // One expected output character with its end-of-item mark
  typedef struct packed {
    char_t ch;
    logic  last;
  } enc_char_t;

  // Holds the expected character stream and checks each output beat against it
  class char_scoreboard;
    enc_char_t expected_chars[$];
    int        errors;
    int        items_seen;
    int        chars_checked;
    int        literal_items;
    int        utf8_items[1:4];

    function new();
      errors        = 0;
      items_seen    = 0;
      chars_checked = 0;
      literal_items = 0;
      for (int k = 1; k <= 4; k++) utf8_items[k] = 0;
    endfunction

    task report(input string what);
      $display("[%0t] MISMATCH after %0d chars: %s", $realtime, chars_checked, what);
      errors++;
    endtask

    function automatic bit passes_unescaped(input logic [CpW-1:0] cp);
      string marks;
      marks = "-._~:/?#[]@!$&'()*+,;=";
      if (cp >= 21'h61 && cp <= 21'h7A) return 1'b1;
      if (cp >= 21'h41 && cp <= 21'h5A) return 1'b1;
      if (cp >= 21'h30 && cp <= 21'h39) return 1'b1;
      for (int k = 0; k < marks.len(); k++) begin
        if (cp == CpW'(marks[k])) return 1'b1;
      end
      return 1'b0;
    endfunction

    function automatic char_t nibble_to_hex(input logic [3:0] d);
      if (d < 4'd10) return ChZero + char_t'(d);
      return ChUpperA + char_t'(d - 4'd10);
    endfunction

    function automatic void push_char(input char_t ch, input logic last);
      enc_char_t e;
      e.ch   = ch;
      e.last = last;
      expected_chars.push_back(e);
    endfunction

    // Predict the percent-encoded characters of one accepted codepoint
    function automatic void note_codepoint(input logic [CpW-1:0] cp);
      byte_t utf8[4];
      int    n;
      items_seen++;
      if (passes_unescaped(cp)) begin
        literal_items++;
        push_char(cp[CharW-1:0], 1'b1);
        return;
      end
      // UTF-8 encode, plain patterns for surrogates and codepoints past 0x10FFFF
      if (cp < 21'h80) begin
        n       = 1;
        utf8[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        n       = 2;
        utf8[0] = {3'b110, cp[10:6]};
        utf8[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
        n       = 3;
        utf8[0] = {4'b1110, cp[15:12]};
        utf8[1] = {2'b10, cp[11:6]};
        utf8[2] = {2'b10, cp[5:0]};
      end else begin
        n       = 4;
        utf8[0] = {5'b11110, cp[20:18]};
        utf8[1] = {2'b10, cp[17:12]};
        utf8[2] = {2'b10, cp[11:6]};
        utf8[3] = {2'b10, cp[5:0]};
      end
      utf8_items[n]++;
      for (int k = 0; k < n; k++) begin
        push_char(ChPercent, 1'b0);
        push_char(nibble_to_hex(utf8[k][7:4]), 1'b0);
        push_char(nibble_to_hex(utf8[k][3:0]), k == n - 1);
      end
    endfunction

    // Compare one output beat with the oldest expected character
    task check_char(input char_t got_ch, input logic got_last);
      enc_char_t e;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last=%0b", got_ch, got_last));
        return;
      end
      e = expected_chars.pop_front();
      if (got_ch !== e.ch) begin
        report($sformatf("out_char 0x%02h, expected 0x%02h", got_ch, e.ch));
      end
      if (got_last !== e.last) begin
        report($sformatf("last_of_item %0b, expected %0b", got_last, e.last));
      end
      chars_checked++;
    endtask

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  bit                  quiet      = 1'b0;
  int                  stall_left = 0;
  char_scoreboard      sb;

  always #10 clk = ~clk;

  url_percent_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Stall the output in random bursts; none in the quiet tail
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 19) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every output beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_char(out_tdata[CharW-1:0], out_tlast);
    end
  end

  // Present one codepoint, hold it until accepted, then maybe idle
  task automatic send_codepoint(input logic [CpW-1:0] cp, input bit allow_gap);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW - CpW){1'b0}}, cp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_codepoint(cp);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ASCII most often, spread over every UTF-8 length, some over the whole 21 bits
  function automatic logic [CpW-1:0] random_codepoint();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) return CpW'($urandom_range(0, 'h7F));
    if (pick < 11) return CpW'($urandom_range('h80, 'h7FF));
    if (pick < 14) return CpW'($urandom_range('h800, 'hFFFF));
    if (pick < 17) return CpW'($urandom_range('h10000, 'h10FFFF));
    return CpW'($urandom);
  endfunction

  initial begin
    logic [CpW-1:0] directed[$];
    directed = '{
      21'h00,     // NUL
      21'h20,     // space
      21'h25,     // percent sign itself is escaped
      21'h60,     // between Z and a
      21'h7F,     // DEL
      21'h61, 21'h7A, 21'h41, 21'h5A, 21'h30, 21'h39,
      21'h2D, 21'h7E, 21'h3D, 21'h27,
      21'h80,     // first non-ASCII: two bytes
      21'h7FF, 21'h800,
      21'hD800, 21'hDFFF,  // surrogates encode plainly
      21'hFFFF, 21'h10000, 21'h10FFFF,
      21'h110000, // beyond Unicode, still four bytes
      21'h1FFFFF,
      21'h161     // low bits look like 'a' but must be escaped
    };
    sb = new();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) send_codepoint(directed[k], 1'b1);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - QuietTail) quiet <= 1'b1;
      send_codepoint(random_codepoint(), i < RandomItems - QuietTail);
    end
    in_tvalid <= 1'b0;

    // Drain, then watch for stray beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Encoded %0d codepoints: %0d unescaped, %0d/%0d/%0d/%0d as 1/2/3/4-byte UTF-8",
             sb.items_seen, sb.literal_items, sb.utf8_items[1], sb.utf8_items[2],
             sb.utf8_items[3], sb.utf8_items[4]);
    $display("Checked %0d output characters with random gaps and output stalls, %0d mismatches",
             sb.chars_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #20_000_000;
    $display("Timed out with %0d characters still expected", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/upe_pkg.sv
rtl/url_percent_encoder.sv
rtl/upe_checker.sv
dv/tb_url_percent_encoder.sv
